// ===== src/signed_int_to_decimal_ascii_defines.svh =====
// Assertion macros shared by the signed_int_to_decimal_ascii RTL.
// No dependencies; included by the modules that assert.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define S2D_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// antecedent implies consequent in the next cycle
`define S2D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/s2d_pkg.sv =====
// Shared types, constants and sizing function for the decimal ASCII printer.
// No dependencies.
package s2d_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int CHAR_WIDTH      = 7;

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 7'd45;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE = 7'd10;

  // decimal digits of 2**(width-1); 1233/4096 approximates log10(2)
  function automatic int digits_for(input int width);
    return (((width - 1) * 1233) >> 12) + 1;
  endfunction

  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic emit_digit;
    logic final_digit;
    logic emit_nl;
  } cmd_t;

  typedef struct packed {
    logic negative;
  } status_t;

endpackage

// ===== src/s2d_datapath.sv =====
// Datapath: magnitude register, shift-add-3 BCD converter and output beat register.
// Depends on s2d_pkg.
module s2d_datapath #(
  parameter int VALUE_WIDTH = s2d_pkg::DEF_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  s2d_pkg::cmd_t                    cmd,
  input  logic [VALUE_WIDTH-1:0]           value,
  output s2d_pkg::status_t                 status,
  output logic [s2d_pkg::CHAR_WIDTH-1:0]   character,
  output logic                             last,
  output logic                             strobe
);
  import s2d_pkg::*;

  localparam int NDIG = digits_for(VALUE_WIDTH);
  localparam int BW   = NDIG * 4;

  logic [VALUE_WIDTH-1:0] mag;
  logic                   negative;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          bcd_adj;
  logic                   started;
  logic [3:0]             top;
  logic                   show;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  assign top  = bcd[BW-1 -: 4];
  assign show = started || (top != 4'd0) || cmd.final_digit;
  assign status.negative = negative;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= value[VALUE_WIDTH-1];
      mag      <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      bcd      <= '0;
    end else if (cmd.step) begin
      bcd <= {bcd_adj[BW-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.emit_digit) begin
      bcd <= {bcd[BW-5:0], 4'd0};
    end
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
    end else if (cmd.emit_digit) begin
      character <= CHAR_ZERO + {3'd0, top};
    end else begin
      character <= CHAR_NEWLINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      strobe  <= 1'b0;
      last    <= 1'b0;
    end else begin
      if (cmd.load) begin
        started <= 1'b0;
      end else if (cmd.emit_digit && show) begin
        started <= 1'b1;
      end
      strobe <= cmd.emit_sign || cmd.emit_nl || (cmd.emit_digit && show);
      last   <= cmd.emit_nl;
    end
  end

endmodule

// ===== src/s2d_ctrl.sv =====
// Controller: sequences load, bit conversion, sign, digit and newline beats.
// Depends on s2d_pkg and signed_int_to_decimal_ascii_defines.svh.
`include "signed_int_to_decimal_ascii_defines.svh"

module s2d_ctrl #(
  parameter int VALUE_WIDTH = s2d_pkg::DEF_VALUE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  s2d_pkg::status_t status,
  output logic             busy,
  output s2d_pkg::cmd_t    cmd
);
  import s2d_pkg::*;

  localparam int NDIG = digits_for(VALUE_WIDTH);
  localparam int CW   = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    SIGN,
    DIGITS,
    NEWLINE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;

  assign busy = (state != IDLE);

  always_comb begin
    cmd             = '0;
    cmd.load        = (state == IDLE) && start;
    cmd.step        = (state == CONV);
    cmd.emit_sign   = (state == SIGN);
    cmd.emit_digit  = (state == DIGITS);
    cmd.final_digit = (state == DIGITS) && (cnt == '0);
    cmd.emit_nl     = (state == NEWLINE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= CONV;
            cnt   <= CW'(VALUE_WIDTH - 1);
          end
        end
        CONV: begin
          if (cnt == '0) begin
            state <= status.negative ? SIGN : DIGITS;
            cnt   <= CW'(NDIG - 1);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        SIGN: begin
          state <= DIGITS;
        end
        DIGITS: begin
          if (cnt == '0) begin
            state <= NEWLINE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        NEWLINE: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `S2D_ASSERT_NEXT(a_start_goes_busy, clk, rst, start && !busy, state == CONV)
  `S2D_ASSERT_IMP(a_sign_only_negative, clk, rst, state == SIGN, status.negative)
  `S2D_ASSERT_NEXT(a_newline_ends_run, clk, rst, state == NEWLINE, state == IDLE)

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Sequence: conversion one bit per cycle through the BCD shifter over all VALUE_WIDTH bits,
// then a beat for '-' on negative values, a slot per decimal digit (10 at 32 bits) and the newline.
// A new start is taken only in idle, once the previous item's newline beat is done.
// Beats leave one per cycle at most; the receiver cannot stall.
// Synchronous active-high reset returns the controller to idle with no beat pending.
// Depends on s2d_pkg, s2d_ctrl and s2d_datapath.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = s2d_pkg::DEF_VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [VALUE_WIDTH-1:0]  value,
  output logic [s2d_pkg::CHAR_WIDTH-1:0] character,
  output logic                           last,
  output logic                           strobe
);
  import s2d_pkg::*;

  cmd_t    cmd;
  status_t status;

  s2d_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  s2d_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .status    (status),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

endmodule
